// File: sv/mpa_pkg.sv
`default_nettype none

package mpa_pkg;

    // default fraction widths
    localparam int COV_FRAC_BITS_DEF  = 12;
    localparam int AXIS_FRAC_BITS_DEF = 14;

    // field widths
    localparam int AREA_W = 32;
    localparam int MOM_W  = 48;
    localparam int COV_W  = 47;
    localparam int AXO_W  = 16;

    // root of (cxx-cyy)^2 + 4*cxy^2 and its radicand
    localparam int ROOT_W = 50;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int HALF_W = 24;

    // axis vector before normalization
    localparam int UA_W        = ROOT_W + 1;
    localparam int NRM_W       = 30;
    localparam int NRM_SHIFT_W = 5;
    localparam int NRM_RAD_W   = 2 * NRM_W + 2;
    localparam int NRM_ROOT_W  = NRM_RAD_W / 2;

    localparam logic [AXO_W-1:0] AXIS_MAX = 16'h7fff;
    localparam logic [COV_W-1:0] COV_MAX  = '1;

    // covariance divider lanes
    localparam int LANE_XX = 0;
    localparam int LANE_YY = 1;
    localparam int LANE_XY = 2;
    localparam int COV_LANES = 3;

    // axis divider lanes
    localparam int LANE_U = 0;
    localparam int LANE_V = 1;
    localparam int AX_LANES = 2;

    typedef struct packed {
        logic area_zero;
        logic xy_neg;
    } cov_sb_t;

    typedef struct packed {
        logic area_zero;
        logic xy_neg;
        logic sat;
        logic xx_gt;
        logic xy_zero;
    } flags_t;

    typedef struct packed {
        flags_t            flags;
        logic [MOM_W-1:0]  sum;
        logic [MOM_W-1:0]  diff;
        logic [MOM_W-1:0]  b2;
    } root_sb_t;

    typedef struct packed {
        flags_t            flags;
        logic [MOM_W-1:0]  major;
        logic [MOM_W-1:0]  minor;
    } eig_t;

    typedef struct packed {
        eig_t              eig;
        logic [NRM_W-1:0]  a;
        logic [NRM_W-1:0]  b;
    } nrm_sb_t;

endpackage

`default_nettype wire

// File: sv/mpa_div_pipe.sv
`default_nettype none

module mpa_div_pipe #(
    parameter int LANES = 1,
    parameter int DEN_W = 32,
    parameter int Q_W   = 16,
    parameter int SB_W  = 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [DEN_W-1:0]             den,
    input  logic [LANES-1:0][DEN_W-1:0]  rem_init,
    input  logic [LANES-1:0][Q_W-1:0]    num_lo,
    input  logic [SB_W-1:0]              in_sb,
    output logic                         out_valid,
    output logic [LANES-1:0][Q_W-1:0]    quo,
    output logic [SB_W-1:0]              out_sb
);

    // one quotient bit per stage, restoring division
    logic [Q_W-1:0]                vld_reg;
    logic [LANES-1:0][DEN_W-1:0]   rem_reg [Q_W];
    logic [LANES-1:0][Q_W-1:0]     nq_reg  [Q_W];
    logic [DEN_W-1:0]              den_reg [Q_W];
    logic [SB_W-1:0]               sb_reg  [Q_W];

    logic [LANES-1:0][DEN_W-1:0]   src_rem [Q_W];
    logic [LANES-1:0][Q_W-1:0]     src_nq  [Q_W];
    logic [DEN_W-1:0]              src_den [Q_W];
    logic [LANES-1:0][DEN_W-1:0]   rem_next [Q_W];
    logic [LANES-1:0][Q_W-1:0]     nq_next  [Q_W];

    // stage sources
    always_comb
    begin
        src_rem[0] = rem_init;
        src_nq[0]  = num_lo;
        src_den[0] = den;
        for (int s = 1; s < Q_W; s++)
        begin
            src_rem[s] = rem_reg[s-1];
            src_nq[s]  = nq_reg[s-1];
            src_den[s] = den_reg[s-1];
        end
    end

    // compare and subtract per stage and lane
    always_comb
    begin
        logic [DEN_W:0] cat;
        logic           ge;
        cat = '0;
        ge  = 1'b0;
        for (int s = 0; s < Q_W; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                cat = {src_rem[s][l], src_nq[s][l][Q_W-1]};
                ge  = cat >= {1'b0, src_den[s]};
                rem_next[s][l] = ge ? DEN_W'(cat - {1'b0, src_den[s]}) : DEN_W'(cat);
                nq_next[s][l]  = {src_nq[s][l][Q_W-2:0], ge};
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[Q_W-2:0], in_valid};
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0] <= in_sb;
            for (int s = 1; s < Q_W; s++)
            begin
                sb_reg[s] <= sb_reg[s-1];
            end
            for (int s = 0; s < Q_W; s++)
            begin
                rem_reg[s] <= rem_next[s];
                nq_reg[s]  <= nq_next[s];
                den_reg[s] <= src_den[s];
            end
        end
    end

    assign out_valid = vld_reg[Q_W-1];
    assign quo       = nq_reg[Q_W-1];
    assign out_sb    = sb_reg[Q_W-1];

endmodule

`default_nettype wire

// File: sv/mpa_sqrt_pipe.sv
`default_nettype none

module mpa_sqrt_pipe #(
    parameter int RAD_W = 100,
    parameter int SB_W  = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [RAD_W-1:0]       rad,
    input  logic [SB_W-1:0]        in_sb,
    output logic                   out_valid,
    output logic [RAD_W/2-1:0]     root,
    output logic [SB_W-1:0]        out_sb
);

    localparam int RT_W  = RAD_W / 2;
    localparam int REM_W = RT_W + 1;

    // one root bit per stage, two radicand bits consumed
    logic [RT_W-1:0]   vld_reg;
    logic [REM_W-1:0]  rem_reg [RT_W];
    logic [RT_W-1:0]   rt_reg  [RT_W];
    logic [RAD_W-1:0]  rad_reg [RT_W];
    logic [SB_W-1:0]   sb_reg  [RT_W];

    logic [REM_W-1:0]  src_rem [RT_W];
    logic [RT_W-1:0]   src_rt  [RT_W];
    logic [RAD_W-1:0]  src_rad [RT_W];
    logic [REM_W-1:0]  rem_next [RT_W];
    logic [RT_W-1:0]   rt_next  [RT_W];

    // stage sources
    always_comb
    begin
        src_rem[0] = '0;
        src_rt[0]  = '0;
        src_rad[0] = rad;
        for (int s = 1; s < RT_W; s++)
        begin
            src_rem[s] = rem_reg[s-1];
            src_rt[s]  = rt_reg[s-1];
            src_rad[s] = rad_reg[s-1];
        end
    end

    // trial subtract per stage
    always_comb
    begin
        logic [REM_W+1:0] cat;
        logic [REM_W+1:0] trial;
        logic             ge;
        cat   = '0;
        trial = '0;
        ge    = 1'b0;
        for (int s = 0; s < RT_W; s++)
        begin
            cat   = {src_rem[s], src_rad[s][RAD_W-1:RAD_W-2]};
            trial = (REM_W+2)'({src_rt[s], 2'b01});
            ge    = cat >= trial;
            rem_next[s] = ge ? REM_W'(cat - trial) : REM_W'(cat);
            rt_next[s]  = {src_rt[s][RT_W-2:0], ge};
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[RT_W-2:0], in_valid};
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0] <= in_sb;
            for (int s = 1; s < RT_W; s++)
            begin
                sb_reg[s] <= sb_reg[s-1];
            end
            for (int s = 0; s < RT_W; s++)
            begin
                rem_reg[s] <= rem_next[s];
                rt_reg[s]  <= rt_next[s];
                rad_reg[s] <= src_rad[s] << 2;
            end
        end
    end

    assign out_valid = vld_reg[RT_W-1];
    assign root      = rt_reg[RT_W-1];
    assign out_sb    = sb_reg[RT_W-1];

endmodule

`default_nettype wire

// File: sv/moment_principal_axes.sv
`default_nettype none
// channel   handshake               payload
// input     in_valid / in_ready     area_moment, var_x_moment, cross_moment, var_y_moment
// output    out_valid / out_ready   eig_major, eig_minor, axis1_*, axis2_*, area_zero, saturated
//
// one region per cycle while out_ready does not hold the pipeline; results pass through
// the pipelined dividers (one quotient bit per stage) and the two square root pipes
// rst_n clears only the valid bits; payload registers are not reset
// the whole pipeline holds while a result waits on out_ready, in_ready follows
// that same hold, so a new transfer is taken whenever the output register frees

module moment_principal_axes #(
    parameter int COV_FRAC_BITS  = mpa_pkg::COV_FRAC_BITS_DEF,
    parameter int AXIS_FRAC_BITS = mpa_pkg::AXIS_FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [31:0]         area_moment,
    input  logic [47:0]         var_x_moment,
    input  logic signed [47:0]  cross_moment,
    input  logic [47:0]         var_y_moment,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [47:0]         eig_major,
    output logic signed [47:0]  eig_minor,
    output logic signed [15:0]  axis1_x,
    output logic signed [15:0]  axis1_y,
    output logic signed [15:0]  axis2_x,
    output logic signed [15:0]  axis2_y,
    output logic                area_zero,
    output logic                saturated
);

    import mpa_pkg::*;

    localparam int COV_Q_W   = MOM_W + COV_FRAC_BITS;
    localparam int AX_Q_W    = AXIS_FRAC_BITS + 1;
    localparam int AX_NUM_W  = NRM_W + 1 + AXIS_FRAC_BITS;
    localparam logic [AXO_W-1:0] AXIS_ONE =
        (AXIS_FRAC_BITS >= 15) ? AXIS_MAX : AXO_W'(1 << AXIS_FRAC_BITS);

    logic adv;
    logic out_valid_reg;

    // global advance: hold everything while the result is not taken
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // covariance division
    logic [COV_LANES-1:0][AREA_W-1:0]  cov_rem_init;
    logic [COV_LANES-1:0][COV_Q_W-1:0] cov_num;
    logic [COV_LANES-1:0][COV_Q_W-1:0] cov_quo;
    logic [MOM_W-1:0]                  xy_mag;
    cov_sb_t                           cov_sb_in;
    cov_sb_t                           cov_sb_out;
    logic                              cov_valid;

    assign xy_mag = cross_moment[MOM_W-1] ? MOM_W'(-cross_moment) : MOM_W'(cross_moment);
    assign cov_rem_init = '0;
    assign cov_num[LANE_XX] = {var_x_moment, {COV_FRAC_BITS{1'b0}}};
    assign cov_num[LANE_YY] = {var_y_moment, {COV_FRAC_BITS{1'b0}}};
    assign cov_num[LANE_XY] = {xy_mag, {COV_FRAC_BITS{1'b0}}};
    assign cov_sb_in.area_zero = (area_moment == '0);
    assign cov_sb_in.xy_neg    = cross_moment[MOM_W-1];

    mpa_div_pipe #(
        .LANES (COV_LANES),
        .DEN_W (AREA_W),
        .Q_W   (COV_Q_W),
        .SB_W  ($bits(cov_sb_t))
    ) u_cov_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (in_valid),
        .den       (area_moment),
        .rem_init  (cov_rem_init),
        .num_lo    (cov_num),
        .in_sb     (cov_sb_in),
        .out_valid (cov_valid),
        .quo       (cov_quo),
        .out_sb    (cov_sb_out)
    );

    // clamp covariance terms
    logic [COV_LANES-1:0][COV_W-1:0] cov_clamped;
    logic [COV_LANES-1:0]            cov_ovf;

    always_comb
    begin
        for (int l = 0; l < COV_LANES; l++)
        begin
            cov_ovf[l]     = |cov_quo[l][COV_Q_W-1:COV_W];
            cov_clamped[l] = cov_ovf[l] ? COV_MAX : cov_quo[l][COV_W-1:0];
        end
    end

    logic                            cl_valid_reg;
    logic [COV_LANES-1:0][COV_W-1:0] cl_cov_reg;
    flags_t                          cl_flags_reg;

    // difference, sum, doubled cross term
    logic                 df_valid_reg;
    root_sb_t             df_sb_reg;
    logic [COV_W-1:0]     df_dmag_reg;
    logic [MOM_W-1:0]     df_diff_next;
    flags_t               df_flags_next;

    assign df_diff_next = MOM_W'({1'b0, cl_cov_reg[LANE_XX]})
                        - MOM_W'({1'b0, cl_cov_reg[LANE_YY]});

    // flags with variance order and zero cross term added
    always_comb
    begin
        df_flags_next         = cl_flags_reg;
        df_flags_next.xx_gt   = cl_cov_reg[LANE_XX] > cl_cov_reg[LANE_YY];
        df_flags_next.xy_zero = (cl_cov_reg[LANE_XY] == '0);
    end

    // partial products of both squares
    logic                  pp_valid_reg;
    root_sb_t              pp_sb_reg;
    logic [2*HALF_W-1:0]   pp_dll_reg, pp_dlh_reg, pp_dhh_reg;
    logic [2*HALF_W-1:0]   pp_bll_reg, pp_blh_reg, pp_bhh_reg;
    logic [HALF_W-1:0]     d_lo, d_hi, b_lo, b_hi;

    assign d_lo = df_dmag_reg[HALF_W-1:0];
    assign d_hi = HALF_W'(df_dmag_reg[COV_W-1:HALF_W]);
    assign b_lo = df_sb_reg.b2[HALF_W-1:0];
    assign b_hi = df_sb_reg.b2[MOM_W-1:HALF_W];

    // squares assembled
    logic             sq_valid_reg;
    root_sb_t         sq_sb_reg;
    logic [RAD_W-1:0] sq_dsq_reg, sq_bsq_reg;

    // radicand
    logic             rd_valid_reg;
    root_sb_t         rd_sb_reg;
    logic [RAD_W-1:0] rd_rad_reg;

    logic              root_valid;
    logic [ROOT_W-1:0] root_val;
    root_sb_t          root_sb;

    mpa_sqrt_pipe #(
        .RAD_W (RAD_W),
        .SB_W  ($bits(root_sb_t))
    ) u_root_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (rd_valid_reg),
        .rad       (rd_rad_reg),
        .in_sb     (rd_sb_reg),
        .out_valid (root_valid),
        .root      (root_val),
        .out_sb    (root_sb)
    );

    // eigenvalues and unnormalized axis
    logic [UA_W-1:0]   eg_wsum;
    logic [ROOT_W-1:0] eg_major_w;
    logic signed [ROOT_W+1:0] eg_mt, eg_mh;
    logic [ROOT_W+1:0] eg_u;
    logic              eg_maj_ovf, eg_min_ovf;
    eig_t              eg_eig_next;

    always_comb
    begin
        eg_wsum    = UA_W'(root_sb.sum) + UA_W'(root_val);
        eg_major_w = eg_wsum[UA_W-1:1];
        eg_maj_ovf = |eg_major_w[ROOT_W-1:MOM_W];
        eg_mt      = $signed({4'b0, root_sb.sum}) - $signed({2'b0, root_val});
        eg_mh      = eg_mt >>> 1;
        eg_min_ovf = !((&eg_mh[ROOT_W+1:MOM_W-1]) || !(|eg_mh[ROOT_W+1:MOM_W-1]));
        eg_u       = {{4{root_sb.diff[MOM_W-1]}}, root_sb.diff} + {2'b0, root_val};

        eg_eig_next.flags     = root_sb.flags;
        eg_eig_next.flags.sat = root_sb.flags.sat | eg_maj_ovf | eg_min_ovf;
        eg_eig_next.major     = eg_maj_ovf ? '1 : eg_major_w[MOM_W-1:0];
        if (!eg_min_ovf)
        begin
            eg_eig_next.minor = eg_mh[MOM_W-1:0];
        end
        else if (eg_mh[ROOT_W+1])
        begin
            eg_eig_next.minor = {1'b1, {(MOM_W-1){1'b0}}};
        end
        else
        begin
            eg_eig_next.minor = {1'b0, {(MOM_W-1){1'b1}}};
        end
    end

    logic            eg_valid_reg;
    eig_t            eg_eig_reg;
    logic [UA_W-1:0] eg_a_reg;
    logic [MOM_W-1:0] eg_b_reg;

    // shift count that brings both components below 2^30
    logic [UA_W-1:0]        lz_v;
    logic [NRM_SHIFT_W-1:0] lz_shift_next;

    always_comb
    begin
        lz_v          = eg_a_reg | UA_W'(eg_b_reg);
        lz_shift_next = '0;
        for (int i = 0; i < UA_W - NRM_W; i++)
        begin
            if (lz_v[NRM_W+i])
            begin
                lz_shift_next = NRM_SHIFT_W'(i + 1);
            end
        end
    end

    logic                   lz_valid_reg;
    eig_t                   lz_eig_reg;
    logic [UA_W-1:0]        lz_a_reg;
    logic [MOM_W-1:0]       lz_b_reg;
    logic [NRM_SHIFT_W-1:0] lz_shift_reg;

    // normalized components
    logic             nr_valid_reg;
    eig_t             nr_eig_reg;
    logic [NRM_W-1:0] nr_a_reg, nr_b_reg;

    // squares of normalized components
    logic               ns_valid_reg;
    nrm_sb_t            ns_sb_reg;
    logic [2*NRM_W-1:0] ns_asq_reg, ns_bsq_reg;

    // norm radicand
    logic                 nd_valid_reg;
    nrm_sb_t              nd_sb_reg;
    logic [NRM_RAD_W-1:0] nd_rad_reg;

    logic                  nrm_valid;
    logic [NRM_ROOT_W-1:0] nrm_root;
    nrm_sb_t               nrm_sb;

    mpa_sqrt_pipe #(
        .RAD_W (NRM_RAD_W),
        .SB_W  ($bits(nrm_sb_t))
    ) u_norm_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (nd_valid_reg),
        .rad       (nd_rad_reg),
        .in_sb     (nd_sb_reg),
        .out_valid (nrm_valid),
        .root      (nrm_root),
        .out_sb    (nrm_sb)
    );

    // rounded numerators for the unit vector
    logic [NRM_ROOT_W-1:0] an_den_next;

    assign an_den_next = (nrm_root == '0) ? NRM_ROOT_W'(1) : nrm_root;

    logic                                  an_valid_reg;
    eig_t                                  an_eig_reg;
    logic [NRM_ROOT_W-1:0]                 an_den_reg;
    logic [AX_LANES-1:0][AX_NUM_W-1:0]     an_num_reg;

    logic [AX_LANES-1:0][NRM_ROOT_W-1:0]   ax_rem_init;
    logic [AX_LANES-1:0][AX_Q_W-1:0]       ax_num_lo;
    logic [AX_LANES-1:0][AX_Q_W-1:0]       ax_quo;
    logic                                  ax_valid;
    eig_t                                  ax_eig;

    always_comb
    begin
        for (int l = 0; l < AX_LANES; l++)
        begin
            ax_rem_init[l] = NRM_ROOT_W'(an_num_reg[l][AX_NUM_W-1:AX_Q_W]);
            ax_num_lo[l]   = an_num_reg[l][AX_Q_W-1:0];
        end
    end

    mpa_div_pipe #(
        .LANES (AX_LANES),
        .DEN_W (NRM_ROOT_W),
        .Q_W   (AX_Q_W),
        .SB_W  ($bits(eig_t))
    ) u_axis_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (an_valid_reg),
        .den       (an_den_reg),
        .rem_init  (ax_rem_init),
        .num_lo    (ax_num_lo),
        .in_sb     (an_eig_reg),
        .out_valid (ax_valid),
        .quo       (ax_quo),
        .out_sb    (ax_eig)
    );

    // final selection
    logic [AXO_W-1:0] ua, ub;
    logic [MOM_W-1:0] out_major_next, out_minor_next;
    logic [AXO_W-1:0] out_a1x_next, out_a1y_next, out_a2x_next, out_a2y_next;
    logic             out_zero_next, out_sat_next;

    always_comb
    begin
        ua = (32'(ax_quo[LANE_U]) > 32'(AXIS_MAX)) ? AXIS_MAX : AXO_W'(ax_quo[LANE_U]);
        ub = (32'(ax_quo[LANE_V]) > 32'(AXIS_MAX)) ? AXIS_MAX : AXO_W'(ax_quo[LANE_V]);
        out_major_next = ax_eig.major;
        out_minor_next = ax_eig.minor;
        out_zero_next  = 1'b0;
        out_sat_next   = ax_eig.flags.sat;
        if (ax_eig.flags.xy_zero)
        begin
            if (ax_eig.flags.xx_gt)
            begin
                out_a1x_next = AXIS_ONE;
                out_a1y_next = '0;
            end
            else
            begin
                out_a1x_next = '0;
                out_a1y_next = AXIS_ONE;
            end
            out_a2x_next = out_a1y_next;
            out_a2y_next = out_a1x_next;
        end
        else
        begin
            out_a1x_next = ua;
            out_a1y_next = ax_eig.flags.xy_neg ? AXO_W'(-ub) : ub;
            out_a2x_next = out_a1y_next;
            out_a2y_next = AXO_W'(-ua);
        end
        if (ax_eig.flags.area_zero)
        begin
            out_major_next = '0;
            out_minor_next = '0;
            out_a1x_next   = '0;
            out_a1y_next   = '0;
            out_a2x_next   = '0;
            out_a2y_next   = '0;
            out_zero_next  = 1'b1;
            out_sat_next   = 1'b0;
        end
    end

    logic [MOM_W-1:0] out_major_reg, out_minor_reg;
    logic [AXO_W-1:0] out_a1x_reg, out_a1y_reg, out_a2x_reg, out_a2y_reg;
    logic             out_zero_reg, out_sat_reg;

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cl_valid_reg  <= 1'b0;
            df_valid_reg  <= 1'b0;
            pp_valid_reg  <= 1'b0;
            sq_valid_reg  <= 1'b0;
            rd_valid_reg  <= 1'b0;
            eg_valid_reg  <= 1'b0;
            lz_valid_reg  <= 1'b0;
            nr_valid_reg  <= 1'b0;
            ns_valid_reg  <= 1'b0;
            nd_valid_reg  <= 1'b0;
            an_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            cl_valid_reg  <= cov_valid;
            df_valid_reg  <= cl_valid_reg;
            pp_valid_reg  <= df_valid_reg;
            sq_valid_reg  <= pp_valid_reg;
            rd_valid_reg  <= sq_valid_reg;
            eg_valid_reg  <= root_valid;
            lz_valid_reg  <= eg_valid_reg;
            nr_valid_reg  <= lz_valid_reg;
            ns_valid_reg  <= nr_valid_reg;
            nd_valid_reg  <= ns_valid_reg;
            an_valid_reg  <= nrm_valid;
            out_valid_reg <= ax_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // clamp
            cl_cov_reg             <= cov_clamped;
            cl_flags_reg.area_zero <= cov_sb_out.area_zero;
            cl_flags_reg.xy_neg    <= cov_sb_out.xy_neg;
            cl_flags_reg.sat       <= |cov_ovf;
            cl_flags_reg.xx_gt     <= 1'b0;
            cl_flags_reg.xy_zero   <= 1'b0;

            // difference and sum
            df_sb_reg.flags <= df_flags_next;
            df_sb_reg.sum  <= MOM_W'(cl_cov_reg[LANE_XX]) + MOM_W'(cl_cov_reg[LANE_YY]);
            df_sb_reg.diff <= df_diff_next;
            df_sb_reg.b2   <= {cl_cov_reg[LANE_XY], 1'b0};
            df_dmag_reg    <= df_diff_next[MOM_W-1] ? COV_W'(-df_diff_next)
                                                    : COV_W'(df_diff_next);

            // partial products
            pp_sb_reg  <= df_sb_reg;
            pp_dll_reg <= d_lo * d_lo;
            pp_dlh_reg <= d_lo * d_hi;
            pp_dhh_reg <= d_hi * d_hi;
            pp_bll_reg <= b_lo * b_lo;
            pp_blh_reg <= b_lo * b_hi;
            pp_bhh_reg <= b_hi * b_hi;

            // squares
            sq_sb_reg  <= pp_sb_reg;
            sq_dsq_reg <= (RAD_W'(pp_dhh_reg) << (2 * HALF_W))
                        + (RAD_W'(pp_dlh_reg) << (HALF_W + 1)) + RAD_W'(pp_dll_reg);
            sq_bsq_reg <= (RAD_W'(pp_bhh_reg) << (2 * HALF_W))
                        + (RAD_W'(pp_blh_reg) << (HALF_W + 1)) + RAD_W'(pp_bll_reg);

            // radicand
            rd_sb_reg  <= sq_sb_reg;
            rd_rad_reg <= sq_dsq_reg + sq_bsq_reg;

            // eigenvalues
            eg_eig_reg <= eg_eig_next;
            eg_a_reg   <= eg_u[UA_W-1:0];
            eg_b_reg   <= root_sb.b2;

            // shift count
            lz_eig_reg   <= eg_eig_reg;
            lz_a_reg     <= eg_a_reg;
            lz_b_reg     <= eg_b_reg;
            lz_shift_reg <= lz_shift_next;

            // normalize
            nr_eig_reg <= lz_eig_reg;
            nr_a_reg   <= NRM_W'(lz_a_reg >> lz_shift_reg);
            nr_b_reg   <= NRM_W'(lz_b_reg >> lz_shift_reg);

            // norm squares
            ns_sb_reg.eig <= nr_eig_reg;
            ns_sb_reg.a   <= nr_a_reg;
            ns_sb_reg.b   <= nr_b_reg;
            ns_asq_reg    <= nr_a_reg * nr_a_reg;
            ns_bsq_reg    <= nr_b_reg * nr_b_reg;

            // norm radicand
            nd_sb_reg  <= ns_sb_reg;
            nd_rad_reg <= NRM_RAD_W'(ns_asq_reg) + NRM_RAD_W'(ns_bsq_reg);

            // axis numerators with half-divisor rounding
            an_eig_reg <= nrm_sb.eig;
            an_den_reg <= an_den_next;
            an_num_reg[LANE_U] <= (AX_NUM_W'(nrm_sb.a) << AXIS_FRAC_BITS)
                                + AX_NUM_W'(an_den_next >> 1);
            an_num_reg[LANE_V] <= (AX_NUM_W'(nrm_sb.b) << AXIS_FRAC_BITS)
                                + AX_NUM_W'(an_den_next >> 1);

            // output register
            out_major_reg <= out_major_next;
            out_minor_reg <= out_minor_next;
            out_a1x_reg   <= out_a1x_next;
            out_a1y_reg   <= out_a1y_next;
            out_a2x_reg   <= out_a2x_next;
            out_a2y_reg   <= out_a2y_next;
            out_zero_reg  <= out_zero_next;
            out_sat_reg   <= out_sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign eig_major = out_major_reg;
    assign eig_minor = out_minor_reg;
    assign axis1_x   = out_a1x_reg;
    assign axis1_y   = out_a1y_reg;
    assign axis2_x   = out_a2x_reg;
    assign axis2_y   = out_a2y_reg;
    assign area_zero = out_zero_reg;
    assign saturated = out_sat_reg;

    // zero area clears every other field
    a_zero_area: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && area_zero |-> eig_major == '0 && eig_minor == '0 && !saturated
            && axis1_x == '0 && axis1_y == '0 && axis2_y == '0)
        else $error("zero area result carries nonzero fields");

    // second axis is the first rotated
    a_axis_rot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> axis2_x == axis1_y)
        else $error("axis2_x differs from axis1_y");

    // major never below minor unless clamped
    a_eig_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !saturated |-> $signed({1'b0, eig_major}) >= $signed({eig_minor[47], eig_minor}))
        else $error("major eigenvalue below minor");

    // axis1_x is not negative on a zero area result
    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $signed(axis1_x) >= 0 || axis1_x == AXIS_ONE || !area_zero)
        else $error("axis1_x negative on zero area");

endmodule

`default_nettype wire
